>>> hdl/fcs_pkg.sv
// shared types and constants for a fletcher-style 64-bit checksum, stored-field skip
package fcs_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 10;
  localparam int SUM_W         = 2 * DATA_W;
  localparam int OUT_TDATA_W   = 72;
  localparam int MAX_WORDS_DEF = 1024;
  localparam int CFG_ADDR_W    = 3;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_CHECKSUM_WORD_POS = 1'b0,
    REG_UPDATE_MODE       = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic              last_word;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] checksum_word_pos;
    logic             update_mode;
  } cfg_t;

endpackage

>>> hdl/fcs_in_reg.sv
// input register stage between the input channel and the accumulator
module fcs_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fcs_pkg::item_t in_item,
  output logic          s_valid,
  output fcs_pkg::item_t s_item,
  input  logic          s_take
);
  import fcs_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || s_take;
  assign valid_nxt = in_valid ? 1'b1 : (s_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

>>> hdl/fcs_accum.sv
// running fletcher sums, stored-field capture and result register
module fcs_accum #(
  parameter int MAX_WORDS = fcs_pkg::MAX_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fcs_pkg::cfg_t                    cfg,
  input  logic                             s_valid,
  input  fcs_pkg::item_t                   s_item,
  output logic                             s_take,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fcs_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fcs_pkg::*;

  localparam int CW    = $clog2(MAX_WORDS + 1);
  localparam int CMP_W = (CW > POS_W + 1) ? CW : POS_W + 1;

  logic [CW-1:0]          count_r, count_nxt;
  logic [DATA_W-1:0]      low_r, low_nxt;
  logic [DATA_W-1:0]      high_r, high_nxt;
  logic [SUM_W-1:0]       stored_r, stored_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [CMP_W-1:0]  count_ext, pos_ext, pos1_ext;
  logic              in_range, hit_low, hit_high;
  logic [DATA_W-1:0] addend;
  logic [SUM_W-1:0]  value;
  logic              ok;
  logic              take_last;

  // a word that ends no block never waits on the output side
  assign s_take    = s_valid && (!s_item.last_word || !out_valid_r || out_tready);
  assign take_last = s_take && s_item.last_word;

  assign count_ext = CMP_W'(count_r);
  assign pos_ext   = CMP_W'(cfg.checksum_word_pos);
  assign pos1_ext  = pos_ext + CMP_W'(1);
  assign in_range  = count_r < CW'(MAX_WORDS);
  assign hit_low   = in_range && (count_ext == pos_ext);
  assign hit_high  = in_range && !hit_low && (count_ext == pos1_ext);

  always_comb begin
    addend     = s_item.data_word;
    stored_nxt = stored_r;
    if (hit_low) begin
      stored_nxt[DATA_W-1:0] = s_item.data_word;
      addend                 = '0;
    end else if (hit_high) begin
      stored_nxt[SUM_W-1:DATA_W] = s_item.data_word;
      addend                     = '0;
    end
  end

  assign count_nxt = in_range ? count_r + CW'(1) : count_r;
  assign low_nxt   = low_r + addend;
  assign high_nxt  = high_r + low_nxt;
  assign value     = {high_nxt, low_nxt};
  assign ok        = cfg.update_mode || (stored_nxt == value);

  always_comb begin
    if (take_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      low_r       <= '0;
      high_r      <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take_last) begin
        count_r  <= '0;
        low_r    <= '0;
        high_r   <= '0;
        stored_r <= '0;
      end else if (s_take) begin
        count_r  <= count_nxt;
        low_r    <= low_nxt;
        high_r   <= high_nxt;
        stored_r <= stored_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      out_data_r <= OUT_TDATA_W'({ok, value});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_WORDS))
    else $error("word count beyond block limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |=> (count_r == '0 && low_r == '0 && high_r == '0 && stored_r == '0))
    else $error("block state not cleared after last word");

  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |=> out_valid_r)
    else $error("no result after last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !take_last)
    else $error("pending result overwritten");
`endif

endmodule

>>> hdl/fletcher64_checksum_with_skip_top.sv
// top level: config registers, input register and checksum accumulator
//
// usage: words of a block enter on the in_ stream, one 32-bit word per
// transfer, in_tlast marking the final word. the two words starting at
// checksum_word_pos are taken as the stored checksum: they add as zero and
// are captured. on the final word one result leaves on the out_ stream:
// out_tdata[63:0] is {high sum, low sum}, out_tdata[64] the match flag
// (always 1 in update mode). blocks of any length follow back to back.
// throughput: one word per cycle while no final word waits on a stalled
// result slot; input and output registers are split, so the two adds per
// word are combinational in the accumulator. a last word accepted on in_
// passes the input register, then the result is registered with out_tvalid.
// a stalled out_tready holds the result; non-final words keep
// flowing, and a final word waits in the input register until the result
// slot frees. reset clears sums, word count, stored field, both valid flags
// and the config registers (position 0, verify mode). config writes on the
// apb port: 0x0 checksum_word_pos, 0x4 update_mode; pready is tied high.
module fletcher64_checksum_with_skip_top #(
  parameter int MAX_WORDS = fcs_pkg::MAX_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: data_word[31:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fcs_pkg::DATA_W-1:0]      in_tdata,
  input  logic                            in_tlast,
  // out_tdata: checksum_value[63:0], checksum_ok[64], zero pad [71:65]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fcs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import fcs_pkg::*;

  logic [POS_W-1:0] word_pos_r;
  logic             update_r;
  logic             wr_en;
  reg_idx_t         reg_idx;
  cfg_t             cfg;
  item_t            in_item, s_item;
  logic             s_valid, s_take;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_pos_r <= '0;
      update_r   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHECKSUM_WORD_POS: word_pos_r <= cfg_pwdata[POS_W-1:0];
        REG_UPDATE_MODE:       update_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHECKSUM_WORD_POS: cfg_prdata = 32'(word_pos_r);
      REG_UPDATE_MODE:       cfg_prdata = 32'(update_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg.checksum_word_pos = word_pos_r;
  assign cfg.update_mode       = update_r;

  assign in_item.data_word = in_tdata;
  assign in_item.last_word = in_tlast;

  fcs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_item   (s_item),
    .s_take   (s_take)
  );

  fcs_accum #(
    .MAX_WORDS (MAX_WORDS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s_valid    (s_valid),
    .s_item     (s_item),
    .s_take     (s_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
